// ===== src/chhc_pkg.sv =====
// chunk header hash check: shared constants and hash step functions
// no dependencies; used by every module of the block
package chhc_pkg;

	localparam int unsigned HASH_W = 32;
	localparam int unsigned HALF_W = 16;
	localparam int unsigned SIDE_W_DEF = 32;

	// seed used when the incoming hash is zero: the pass's byte length
	localparam logic [HASH_W-1:0] SEED_WORD = 32'd4;
	localparam logic [HASH_W-1:0] SEED_HALF = 32'd2;

	// one main round over a 32-bit word, low half first
	function automatic logic [HASH_W-1:0] mix4(input logic [HASH_W-1:0] h_in,
			input logic [HASH_W-1:0] word);
		logic [HASH_W-1:0] h;
		logic [HASH_W-1:0] t;
		h = h_in + {16'd0, word[15:0]};
		t = {5'd0, word[31:16], 11'd0} ^ h;
		h = {h[15:0], 16'd0} ^ t;
		h = h + {11'd0, h[31:11]};
		return h;
	endfunction

	// two-byte tail round
	function automatic logic [HASH_W-1:0] mix2(input logic [HASH_W-1:0] h_in,
			input logic [HALF_W-1:0] half);
		logic [HASH_W-1:0] h;
		h = h_in + {16'd0, half};
		h = h ^ {h[20:0], 11'd0};
		h = h + {17'd0, h[31:17]};
		return h;
	endfunction

	// avalanche, first three steps
	function automatic logic [HASH_W-1:0] aval_front(input logic [HASH_W-1:0] h_in);
		logic [HASH_W-1:0] h;
		h = h_in ^ {h_in[28:0], 3'd0};
		h = h + {5'd0, h[31:5]};
		h = h ^ {h[27:0], 4'd0};
		return h;
	endfunction

	// avalanche, last three steps
	function automatic logic [HASH_W-1:0] aval_back(input logic [HASH_W-1:0] h_in);
		logic [HASH_W-1:0] h;
		h = h_in + {17'd0, h_in[31:17]};
		h = h ^ {h[6:0], 25'd0};
		h = h + {6'd0, h[31:6]};
		return h;
	endfunction

endpackage

// ===== src/chhc_ifs.sv =====
// chunk header hash check: valid/ready channel interfaces for header and result words
// depends on chhc_pkg
interface chhc_hdr_if;
	import chhc_pkg::*;
	logic                valid;
	logic                ready;
	logic [HASH_W-1:0]   chunk_id;
	logic [HALF_W-1:0]   chunk_version;
	logic [HASH_W-1:0]   chunk_length;
	logic [HASH_W-1:0]   stored_sum;

	modport source (output valid, chunk_id, chunk_version, chunk_length, stored_sum,
		input ready);
	modport sink (input valid, chunk_id, chunk_version, chunk_length, stored_sum,
		output ready);
endinterface

interface chhc_res_if;
	import chhc_pkg::*;
	logic                valid;
	logic                ready;
	logic [HASH_W-1:0]   header_sum;
	logic                corrupt;

	modport source (output valid, header_sum, corrupt, input ready);
	modport sink (input valid, header_sum, corrupt, output ready);
endinterface

// ===== src/chhc_pass.sv =====
// chunk header hash check: one hash pass as two pipeline stages
// depends on chhc_pkg; carries a side payload of SIDE_W bits alongside the hash
module chhc_pass
	import chhc_pkg::*;
#(
	parameter int unsigned SIDE_W = SIDE_W_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              up_valid,
	output logic              up_ready,
	input  logic [HASH_W-1:0] hash_in,
	input  logic [HASH_W-1:0] word,
	input  logic              half,
	input  logic [SIDE_W-1:0] side_in,
	output logic              dn_valid,
	input  logic              dn_ready,
	output logic [HASH_W-1:0] hash_out,
	output logic [SIDE_W-1:0] side_out
);

	logic              valid_s1, valid_s2;
	logic [HASH_W-1:0] h_s1, h_s2;
	logic [SIDE_W-1:0] side_s1, side_s2;
	logic              ready_s1, ready_s2;
	logic [HASH_W-1:0] seed, h_start, h_mix;

	assign ready_s2 = !valid_s2 || dn_ready;
	assign ready_s1 = !valid_s1 || ready_s2;
	assign up_ready = ready_s1;

	// zero incoming hash is replaced by the pass's byte length
	always_comb begin
		seed    = half ? SEED_HALF : SEED_WORD;
		h_start = (hash_in == '0) ? seed : hash_in;
		h_mix   = half ? mix2(h_start, word[HALF_W-1:0]) : mix4(h_start, word);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (ready_s1) begin
				valid_s1 <= up_valid;
			end
			if (ready_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (up_valid && ready_s1) begin
			h_s1    <= aval_front(h_mix);
			side_s1 <= side_in;
		end
		if (valid_s1 && ready_s2) begin
			h_s2    <= aval_back(h_s1);
			side_s2 <= side_s1;
		end
	end

	assign dn_valid = valid_s2;
	assign hash_out = h_s2;
	assign side_out = side_s2;

endmodule

// ===== src/chhc_chk.sv =====
// chunk header hash check: compare against the stored sum and hold the result word
// depends on chhc_pkg and chhc_res_if
module chhc_chk
	import chhc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              up_valid,
	output logic              up_ready,
	input  logic [HASH_W-1:0] hash_in,
	input  logic [HASH_W-1:0] stored_sum,
	chhc_res_if.source        res
);

	logic              valid_s1;
	logic [HASH_W-1:0] sum_s1;
	logic              corrupt_s1;

	assign up_ready = !valid_s1 || res.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (up_ready) begin
			valid_s1 <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_valid && up_ready) begin
			sum_s1     <= hash_in;
			corrupt_s1 <= (hash_in != stored_sum);
		end
	end

	assign res.valid      = valid_s1;
	assign res.header_sum = sum_s1;
	assign res.corrupt    = corrupt_s1;

endmodule

// ===== src/chunk_header_hash_check.sv =====
// chunk header hash check: top level, three chained hash passes and the compare stage
// depends on chhc_pkg, chhc_ifs, chhc_pass and chhc_chk
//
// usage
//   hdr (sink) takes one header word per handshake: chunk_id, chunk_version,
//   chunk_length and the stored_sum read from the header
//   res (source) gives one result word per header: header_sum, the chained
//   hash over id, version and length, and corrupt, set when it differs from
//   stored_sum
//   the hash runs as three passes (4 id bytes, 2 version bytes, 4 length
//   bytes), each cut into mix plus first half of the avalanche, then the
//   second half; a final stage compares and holds the result
//   a word accepted on hdr runs through the stages of the passes and the compare
//   stage to res; one word is accepted every cycle as long as res is taken
//   each stage has its own valid bit and ready, so a stall on res fills the
//   empty stages first; hdr.ready drops only when all 7 stages hold a word
//   reset clears the valid bits only; nothing is lost or repeated on a stall
module chunk_header_hash_check
	import chhc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	chhc_hdr_if.sink   hdr,
	chhc_res_if.source res
);

	localparam int unsigned SIDE1_W = HALF_W + 2 * HASH_W;
	localparam int unsigned SIDE2_W = 2 * HASH_W;
	localparam int unsigned SIDE3_W = HASH_W;

	// pass 1: id word, side carries version, length, stored sum
	logic               p1_valid, p1_ready;
	logic [HASH_W-1:0]  p1_hash;
	logic [SIDE1_W-1:0] p1_side;
	// pass 2: version half, side carries length, stored sum
	logic               p2_valid, p2_ready;
	logic [HASH_W-1:0]  p2_hash;
	logic [SIDE2_W-1:0] p2_side;
	// pass 3: length word, side carries stored sum
	logic               p3_valid, p3_ready;
	logic [HASH_W-1:0]  p3_hash;
	logic [SIDE3_W-1:0] p3_side;

	chhc_pass #(.SIDE_W(SIDE1_W)) u_pass_id (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (hdr.valid),
		.up_ready (hdr.ready),
		.hash_in  ('0),
		.word     (hdr.chunk_id),
		.half     (1'b0),
		.side_in  ({hdr.chunk_version, hdr.chunk_length, hdr.stored_sum}),
		.dn_valid (p1_valid),
		.dn_ready (p1_ready),
		.hash_out (p1_hash),
		.side_out (p1_side)
	);

	// version sits in the top bits of the side word
	chhc_pass #(.SIDE_W(SIDE2_W)) u_pass_ver (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (p1_valid),
		.up_ready (p1_ready),
		.hash_in  (p1_hash),
		.word     ({{(HASH_W-HALF_W){1'b0}}, p1_side[SIDE1_W-1:SIDE2_W]}),
		.half     (1'b1),
		.side_in  (p1_side[SIDE2_W-1:0]),
		.dn_valid (p2_valid),
		.dn_ready (p2_ready),
		.hash_out (p2_hash),
		.side_out (p2_side)
	);

	chhc_pass #(.SIDE_W(SIDE3_W)) u_pass_len (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (p2_valid),
		.up_ready (p2_ready),
		.hash_in  (p2_hash),
		.word     (p2_side[SIDE2_W-1:SIDE3_W]),
		.half     (1'b0),
		.side_in  (p2_side[SIDE3_W-1:0]),
		.dn_valid (p3_valid),
		.dn_ready (p3_ready),
		.hash_out (p3_hash),
		.side_out (p3_side)
	);

	// compare with the stored sum and hold the result word
	chhc_chk u_chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.up_valid   (p3_valid),
		.up_ready   (p3_ready),
		.hash_in    (p3_hash),
		.stored_sum (p3_side),
		.res        (res)
	);

endmodule
